### sv/assert_macros.svh
// Assertion macros shared by the sorted insert table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SIT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SIT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SIT_ASSERT(lbl, prop, msg)
`define SIT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### sv/sit_pkg.sv
// Types, codes and default sizes of the sorted insert table.
`timescale 1ns / 1ps
package sit_pkg;

  localparam int DEPTH_DEF        = 16;
  localparam int KEY_BITS_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int INDEX_W    = 4;
  localparam int COUNT_W    = 5;
  localparam int LIMIT_W    = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  localparam logic REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_READ_TOP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

### sv/sit_if.sv
// Request and response channel interfaces of the sorted insert table.
`timescale 1ns / 1ps
interface sit_req_if import sit_pkg::*; #(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [KEY_BITS-1:0]     item_key;
  logic [PAYLOAD_BITS-1:0] item_payload;
  logic [INDEX_W-1:0]      item_index;

  modport source (output valid, operation, item_key, item_payload, item_index,
                  input ready);
  modport sink   (input valid, operation, item_key, item_payload, item_index,
                  output ready);
endinterface

interface sit_rsp_if import sit_pkg::*; #(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic [KEY_BITS-1:0]     out_key;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, status, out_key, out_payload, entry_count,
                  input ready);
  modport sink   (input valid, status, out_key, out_payload, entry_count,
                  output ready);
endinterface

### sv/sit_cell.sv
// One table slot: holds an entry, compares against the new key, shifts with its neighbors.
`timescale 1ns / 1ps
module sit_cell import sit_pkg::*; #(
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int CNT_W        = 5,
  parameter int CMP_W        = 5,
  parameter int POS          = 0
) (
  input  logic                    clk_i,
  input  cell_ctrl_t              ctrl_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [INDEX_W-1:0]      rem_idx_i,
  input  logic [KEY_BITS-1:0]     new_key_i,
  input  logic [PAYLOAD_BITS-1:0] new_payload_i,
  input  logic                    left_gt_i,
  input  logic [KEY_BITS-1:0]     left_key_i,
  input  logic [PAYLOAD_BITS-1:0] left_payload_i,
  input  logic [KEY_BITS-1:0]     right_key_i,
  input  logic [PAYLOAD_BITS-1:0] right_payload_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    gt_o
);

  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic                    occupied;
  logic                    at_or_after;

  assign occupied    = CMP_W'(POS) < CMP_W'(count_i);
  assign at_or_after = CMP_W'(POS) >= CMP_W'(rem_idx_i);
  assign gt_o        = occupied && (key_q > new_key_i);

  always_comb begin
    key_d     = key_q;
    payload_d = payload_q;
    if (ctrl_i.ins && !gt_o) begin
      if (left_gt_i) begin
        key_d     = new_key_i;
        payload_d = new_payload_i;
      end else begin
        key_d     = left_key_i;
        payload_d = left_payload_i;
      end
    end else if (ctrl_i.rem && at_or_after) begin
      key_d     = right_key_i;
      payload_d = right_payload_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    payload_q <= payload_d;
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;

endmodule

### sv/sit_cfg_regs.sv
// APB configuration register holding the capacity limit.
`timescale 1ns / 1ps
module sit_cfg_regs import sit_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [LIMIT_W-1:0]    limit_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic               hit;

  assign pready = 1'b1;
  assign hit    = paddr[2] == REG_CAPACITY_LIMIT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata  = hit ? CFG_DATA_W'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

### sv/sorted_insert_table.sv
// Top level of the sorted insert table: cell chain, request decode and response register.
//
// A bounded table of (key, payload) entries kept in descending key order.
// Requests arrive on req_i (valid/ready): insert, remove at index, or read
// top. Each request gives exactly one response on rsp_o with a status, the
// removed or top entry, and the entry count after the request.
// Each slot is a cell; on an insert every cell compares its key with the new
// key and keeps, shifts right or loads the new entry; on a remove every cell
// at or past the index takes its right neighbor. The whole update is done in
// the cycle that accepts the request. The response is registered and is valid
// in the cycle after the request is accepted.
// Throughput: one request per cycle while the response side keeps up.
// A stalled response is held in the output register; req_i.ready stays high
// as long as that register is empty or being drained in the same cycle.
// Reset empties the table (count to zero, no response pending) and sets the
// capacity limit to 16; the APB register at address 0 changes that limit.
// The user must write it only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_insert_table import sit_pkg::*; #(
  parameter int DEPTH        = DEPTH_DEF,
  parameter int KEY_BITS     = KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  sit_req_if.sink               req_i,
  sit_rsp_if.source             rsp_o
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MAX_A  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int CMP_W  = (MAX_A > LIMIT_W) ? MAX_A : LIMIT_W;

  logic [LIMIT_W-1:0]      limit;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    accept;
  logic                    full;
  logic                    in_range;
  cell_ctrl_t              ctrl;
  status_e                 status_d;
  logic [KEY_BITS-1:0]     rkey_d, sel_key;
  logic [PAYLOAD_BITS-1:0] rpay_d, sel_payload;

  logic                    rsp_valid_q;
  status_e                 status_q;
  logic [KEY_BITS-1:0]     rkey_q;
  logic [PAYLOAD_BITS-1:0] rpay_q;

  logic [KEY_BITS-1:0]     key_w     [DEPTH];
  logic [PAYLOAD_BITS-1:0] payload_w [DEPTH];
  logic                    gt_w      [DEPTH];

  sit_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_gt;
    logic [KEY_BITS-1:0]     left_key, right_key;
    logic [PAYLOAD_BITS-1:0] left_payload, right_payload;

    if (i == 0) begin : g_head
      assign left_gt      = 1'b1;
      assign left_key     = '0;
      assign left_payload = '0;
    end else begin : g_link_left
      assign left_gt      = gt_w[i-1];
      assign left_key     = key_w[i-1];
      assign left_payload = payload_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_key     = key_w[i];
      assign right_payload = payload_w[i];
    end else begin : g_link_right
      assign right_key     = key_w[i+1];
      assign right_payload = payload_w[i+1];
    end

    sit_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CNT_W        (CNT_W),
      .CMP_W        (CMP_W),
      .POS          (i)
    ) u_cell (
      .clk_i           (clk_i),
      .ctrl_i          (ctrl),
      .count_i         (count_q),
      .rem_idx_i       (req_i.item_index),
      .new_key_i       (req_i.item_key),
      .new_payload_i   (req_i.item_payload),
      .left_gt_i       (left_gt),
      .left_key_i      (left_key),
      .left_payload_i  (left_payload),
      .right_key_i     (right_key),
      .right_payload_i (right_payload),
      .key_o           (key_w[i]),
      .payload_o       (payload_w[i]),
      .gt_o            (gt_w[i])
    );
  end

  always_comb begin
    sel_key     = '0;
    sel_payload = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == CMP_W'(req_i.item_index)) begin
        sel_key     = sel_key | key_w[i];
        sel_payload = sel_payload | payload_w[i];
      end
    end
  end

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (CMP_W'(count_q) >= CMP_W'(limit)) || (count_q == CNT_W'(DEPTH));
  assign in_range    = CMP_W'(req_i.item_index) < CMP_W'(count_q);

  always_comb begin
    status_d = ST_OK;
    rkey_d   = '0;
    rpay_d   = '0;
    ctrl     = '0;
    count_d  = count_q;
    unique case (op_e'(req_i.operation))
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!in_range) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.rem = accept;
          rkey_d   = sel_key;
          rpay_d   = sel_payload;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_READ_TOP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rkey_d = key_w[0];
          rpay_d = payload_w[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rkey_q   <= rkey_d;
      rpay_q   <= rpay_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = rkey_q;
  assign rsp_o.out_payload = rpay_q;
  assign rsp_o.entry_count = COUNT_W'(count_q);

  `SIT_ASSERT_NEVER(a_count_bound, count_q > CNT_W'(DEPTH), "entry count above depth")
  `SIT_ASSERT(a_full_holds, accept && req_i.operation == OP_INSERT && full |=> count_q == $past(count_q), "failed insert changed count")
  `SIT_ASSERT(a_insert_inc, accept && ctrl.ins |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)), "insert did not add one entry")
  `SIT_ASSERT_NEVER(a_stall_blocks, rsp_valid_q && !rsp_o.ready && req_i.ready, "request taken while response stalled")
  `SIT_ASSERT(a_sorted_head, count_q >= CNT_W'(2) |-> key_w[0] >= key_w[1], "head entries out of order")

endmodule
